@@ rtl/assert_macros.svh @@
// Assertion macros used by the RTL controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Antecedent implies consequent in the cycle after
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

@@ rtl/sitda_pkg.sv @@
// Types and constants of the signed integer to decimal text converter
package sitda_pkg;

    localparam int VALUE_W       = 32;
    localparam int CHAR_W        = 6;
    localparam int DIGITS        = 10;
    localparam int BCD_W         = DIGITS * 4;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(CONV_STEPS);
    localparam int COUNT_W       = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    typedef struct packed {
        logic load;
        logic step;
        logic align;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic last;
    } status_t;

endpackage

@@ rtl/sitda_if.sv @@
// Valid/ready channel interfaces for the integer input and the character output
interface sitda_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sitda_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if;
    logic                          valid;
    logic                          ready;
    logic [sitda_pkg::CHAR_W-1:0]  character;
    logic                          last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

@@ rtl/sitda_datapath.sv @@
// Datapath: magnitude, shift-add-3 BCD conversion, alignment and character output
module sitda_datapath
(
    input  logic                                 clk,
    input  logic signed [sitda_pkg::VALUE_W-1:0] value,
    input  sitda_pkg::cmd_t                      cmd,
    output sitda_pkg::status_t                   stat,
    output logic        [sitda_pkg::CHAR_W-1:0]  character,
    output logic                                 last
);

    logic [sitda_pkg::VALUE_W-1:0] mag_reg,   mag_next;
    logic [sitda_pkg::BCD_W-1:0]   bcd_reg,   bcd_next;
    logic                          neg_reg,   neg_next;
    logic [sitda_pkg::COUNT_W-1:0] left_reg,  left_next;

    logic [sitda_pkg::VALUE_W-1:0] mag_step;
    logic [sitda_pkg::BCD_W-1:0]   bcd_step;
    logic [3:0]                    nib;
    logic [sitda_pkg::COUNT_W-1:0] nd;
    logic [5:0]                    shamt;

    // Shift-add-3 over four bits
    always_comb
    begin
        mag_step = mag_reg;
        bcd_step = bcd_reg;
        nib      = '0;
        for (int s = 0; s < sitda_pkg::BITS_PER_STEP; s++)
        begin
            for (int d = 0; d < sitda_pkg::DIGITS; d++)
            begin
                nib = bcd_step[d*4 +: 4];
                if (nib >= 4'd5)
                begin
                    bcd_step[d*4 +: 4] = nib + 4'd3;
                end
            end
            {bcd_step, mag_step} = {bcd_step, mag_step} << 1;
        end
    end

    // Digit count, at least one
    always_comb
    begin
        nd = sitda_pkg::COUNT_W'(1);
        for (int d = 1; d < sitda_pkg::DIGITS; d++)
        begin
            if (bcd_reg[d*4 +: 4] != 4'd0)
            begin
                nd = sitda_pkg::COUNT_W'(d + 1);
            end
        end
        shamt = 6'(({2'b00, sitda_pkg::COUNT_W'(sitda_pkg::DIGITS)} - {2'b00, nd}) << 2);
    end

    always_comb
    begin
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        neg_next  = neg_reg;
        left_next = left_reg;
        if (cmd.load)
        begin
            neg_next = value[sitda_pkg::VALUE_W-1];
            mag_next = value[sitda_pkg::VALUE_W-1] ? (sitda_pkg::VALUE_W'(0) - $unsigned(value))
                                                   : $unsigned(value);
            bcd_next = '0;
        end
        else if (cmd.step)
        begin
            mag_next = mag_step;
            bcd_next = bcd_step;
        end
        else if (cmd.align)
        begin
            bcd_next  = bcd_reg << shamt;
            left_next = nd + sitda_pkg::COUNT_W'(neg_reg);
        end
        else if (cmd.advance)
        begin
            left_next = left_reg - sitda_pkg::COUNT_W'(1);
            if (neg_reg)
            begin
                neg_next = 1'b0;
            end
            else
            begin
                bcd_next = bcd_reg << 4;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        left_reg <= left_next;
    end

    assign last      = (left_reg == sitda_pkg::COUNT_W'(1));
    assign stat.last = last;
    assign character = neg_reg ? sitda_pkg::CHAR_MINUS
                               : sitda_pkg::CHAR_ZERO
                                 + {2'b00, bcd_reg[sitda_pkg::BCD_W-1 -: 4]};

endmodule

@@ rtl/sitda_ctrl.sv @@
// Controller: sequences load, conversion steps, alignment and character transfers
`include "assert_macros.svh"

module sitda_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  sitda_pkg::status_t stat,
    output sitda_pkg::cmd_t    cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CONV  = 2'd1;
    localparam logic [1:0] S_ALIGN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    localparam logic [sitda_pkg::STEP_CNT_W-1:0] STEP_LAST =
        sitda_pkg::STEP_CNT_W'(sitda_pkg::CONV_STEPS - 1);

    logic [1:0]                      state_reg, state_next;
    logic [sitda_pkg::STEP_CNT_W-1:0] step_reg,  step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                if (in_valid)
                begin
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                step_next = step_reg + sitda_pkg::STEP_CNT_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_ALIGN;
                end
            end
            S_ALIGN:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_ready && stat.last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_EMIT);
    assign cmd.load    = in_ready && in_valid;
    assign cmd.step    = (state_reg == S_CONV);
    assign cmd.align   = (state_reg == S_ALIGN);
    assign cmd.advance = out_valid && out_ready;

    `ASSERT_IMPL(a_no_overlap, in_ready, !out_valid)
    `ASSERT_NEXT(a_run_continues, out_valid && out_ready && !stat.last, out_valid)
    `ASSERT_NEXT(a_run_ends, out_valid && out_ready && stat.last, in_ready)
    `ASSERT_NEXT(a_conv_length, cmd.step && step_reg == STEP_LAST, cmd.align)

endmodule

@@ rtl/signed_int_to_decimal_ascii.sv @@
// Top level: signed 32-bit integer to decimal ASCII character stream
//
// sample: valid/ready channel carrying one signed 32-bit value per transfer.
// text:   valid/ready channel carrying one ASCII character per transfer,
//         most significant first, '-' leading for negative values, with
//         last set on the final character. Runs are 1 to 11 characters.
// One value is converted at a time. After a sample transfer the value is
// converted to BCD four bits per cycle, then an alignment step moves the
// digits to the top of the register before the first character is valid.
// A new value is taken only once the last character of the run is taken.
// The 8-step BCD shifter and the single output channel set the throughput.
// sample.ready is high only while no run is in progress.
// When the receiver stalls, the current character holds on text until it
// is taken; nothing is lost or repeated.
// Reset (rst_n low, asynchronous) drops any run in progress and returns
// the block to waiting for a sample.
module signed_int_to_decimal_ascii
(
    input  logic        clk,
    input  logic        rst_n,
    sitda_in_if.sink    sample,
    sitda_out_if.source text
);

    sitda_pkg::cmd_t    cmd;
    sitda_pkg::status_t stat;

    sitda_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (text.valid),
        .out_ready (text.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sitda_datapath u_datapath
    (
        .clk       (clk),
        .value     (sample.value),
        .cmd       (cmd),
        .stat      (stat),
        .character (text.character),
        .last      (text.last)
    );

endmodule

@@ tb/signed_int_to_decimal_ascii_checker.sv @@
// Checker for the decimal text converter: predicts each character run and compares transfers
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    input  logic                          sample_ready,
    input  logic [sitda_pkg::VALUE_W-1:0] sample_value,
    input  logic                          text_valid,
    input  logic                          text_ready,
    input  logic [sitda_pkg::CHAR_W-1:0]  text_character,
    input  logic                          text_last,
    output int                            errors,
    output int                            pending,
    output int                            chars_checked
);

    localparam int unsigned RADIX = 10;

    typedef struct packed {
        logic [sitda_pkg::CHAR_W-1:0] character;
        logic                         last;
    } text_char_t;

    text_char_t text_expected[$];
    int         mismatches = 0;
    int         pending_q  = 0;
    int         checked    = 0;

    assign errors        = mismatches;
    assign pending       = pending_q;
    assign chars_checked = checked;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic void queue_decimal_text(input logic [sitda_pkg::VALUE_W-1:0] value);
        logic [3:0]                    digits[sitda_pkg::DIGITS];
        logic [sitda_pkg::VALUE_W-1:0] magnitude;
        logic                          negative;
        int                            ndigits;
        int                            total;
        int                            pos;
        text_char_t                    ch;

        negative  = value[sitda_pkg::VALUE_W-1];
        magnitude = negative ? -value : value;
        ndigits   = 0;
        do
        begin
            digits[ndigits] = 4'(magnitude % RADIX);
            ndigits++;
            magnitude = magnitude / RADIX;
        end
        while (magnitude != 0 && ndigits < sitda_pkg::DIGITS);

        total = ndigits + (negative ? 1 : 0);
        pos   = 0;
        if (negative)
        begin
            ch.character = sitda_pkg::CHAR_MINUS;
            ch.last      = (pos == total - 1);
            text_expected.push_back(ch);
            pos++;
        end
        for (int d = ndigits - 1; d >= 0; d--)
        begin
            ch.character = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_W'(digits[d]);
            ch.last      = (pos == total - 1);
            text_expected.push_back(ch);
            pos++;
        end
    endfunction

    always @(posedge clk)
    begin
        text_char_t want;

        if (rst_n)
        begin
            if (sample_valid && sample_ready)
                queue_decimal_text(sample_value);
            if (text_valid && text_ready)
            begin
                if (text_expected.size() == 0)
                    report_mismatch($sformatf("character %0d with no run pending",
                                              text_character));
                else
                begin
                    want = text_expected.pop_front();
                    checked++;
                    if (text_character !== want.character)
                        report_mismatch($sformatf("character %0d, want %0d",
                                                  text_character, want.character));
                    if (text_last !== want.last)
                        report_mismatch($sformatf("last %b, want %b on character %0d",
                                                  text_last, want.last, want.character));
                end
            end
        end
        pending_q <= text_expected.size();
    end

endmodule

@@ tb/signed_int_to_decimal_ascii_tb.sv @@
// Testbench top: drives integers into the converter, stalls the text channel, gives the verdict
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_tb;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 470;
    localparam int TAIL_ITEMS   = 60;
    localparam int DRAIN_EVERY  = 100;
    localparam int SETTLE       = 40;

    logic clk = 1'b0;
    logic rst_n;
    bit   quiet_tail = 1'b0;
    int   cycle_count = 0;
    int   values_sent = 0;
    int   errors;
    int   pending;
    int   chars_checked;

    sitda_in_if  sample_ch();
    sitda_out_if text_ch();

    signed_int_to_decimal_ascii u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .text   (text_ch)
    );

    signed_int_to_decimal_ascii_checker u_chk
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_ch.valid),
        .sample_ready   (sample_ch.ready),
        .sample_value   (sample_ch.value),
        .text_valid     (text_ch.valid),
        .text_ready     (text_ch.ready),
        .text_character (text_ch.character),
        .text_last      (text_ch.last),
        .errors         (errors),
        .pending        (pending),
        .chars_checked  (chars_checked)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycle_count, pending);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [sitda_pkg::VALUE_W-1:0] pick_value();
        longint span;
        longint mag;
        bit     negative;

        span     = 1;
        negative = 1'($urandom_range(0, 1));
        repeat ($urandom_range(0, 9)) span *= 10;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return sitda_pkg::VALUE_W'($urandom_range(0, 2000))
                      - sitda_pkg::VALUE_W'(1000);
            2:
            begin
                mag = span + longint'({$urandom, $urandom} % longint'(9 * span));
                if (mag > 64'd2147483648)
                    mag = mag % 64'd2147483649;
            end
            default: mag = span - longint'($urandom_range(0, 1));
        endcase
        return negative ? sitda_pkg::VALUE_W'(-mag) : sitda_pkg::VALUE_W'(mag);
    endfunction

    task automatic send_value(input logic [sitda_pkg::VALUE_W-1:0] value, input bit allow_gap);
        if (allow_gap && !quiet_tail && $urandom_range(0, 3) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.value <= value;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        values_sent++;
    endtask

    task automatic drain_text();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        text_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                text_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                text_ch.ready <= 1'b1;
                repeat (quiet_tail ? 1 : $urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [sitda_pkg::VALUE_W-1:0] directed[$];

        directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                     -32'sd100, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001,
                     32'd1000000000, 32'd999999999, -32'sd999999999, -32'sd1000000000,
                     32'd1234567890, -32'sd1234567890, 32'h5555_5555, 32'haaaa_aaaa,
                     32'd5, -32'sd7};

        rst_n           <= 1'b0;
        sample_ch.valid <= 1'b0;
        sample_ch.value <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_value(directed[i], 1'b1);
        drain_text();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - TAIL_ITEMS)
                quiet_tail = 1'b1;
            if (i > 0 && i % DRAIN_EVERY == 0)
                drain_text();
            send_value(pick_value(), (i / 40) % 3 != 2);
        end
        sample_ch.valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);

        $display("converted %0d integers (extremes, zero, every digit count, both signs)",
                 values_sent);
        $display("checked %0d characters under random input gaps and output stalls",
                 chars_checked);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
